FILE: hdl/gesa_pkg.sv
// Shared types and constants for the graph embedding scatter-accumulate block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
package gesa_pkg;
    localparam int MAX_NODES  = 1024;
    localparam int MAX_LABELS = 16;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int LABEL_W    = $clog2(MAX_LABELS);
    localparam int Z_AW       = NODE_W + LABEL_W;
    localparam int COUNT_W    = 11;
    localparam int DATA_W     = 32;
    localparam int STEP_W     = $clog2(DATA_W);
    localparam int IN_W       = 64;
    localparam int OUT_W      = 40;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_EDGE  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NODE  = 2'd1;
    localparam logic [1:0] ST_LABEL = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    localparam logic REG_NUM_NODES  = 1'b0;
    localparam logic REG_NUM_LABELS = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_LA, S_LB, S_CHK,
        S_DIV, S_ZRD, S_ACC, S_RDZ, S_RESP
    } state_t;
endpackage

FILE: hdl/graph_embedding_scatter_accumulate.sv
// Top level of the graph embedding scatter-accumulate block.
// Depends on gesa_pkg; holds the label memory, count registers and embedding memory.
`timescale 1ns / 1ps
// Sequence: load, write and commands rejected on node or label range pass S_DISP to S_RESP;
//   a valid read adds S_RDZ; an edge reads labels and counts (S_LA, S_LB), checks (S_CHK), then
//   per entry (two if the nodes differ) does a 32-step bit-serial divide and read-modify-write.
// Flow control: one beat at a time; s_tready is high only in S_IDLE, entered from S_RESP as the
//   result is registered; S_RESP holds while a previous result still waits for m_tready.
// Reset: asynchronous, active low; then a clearing pass zeroes every entry of the embedding
//   memory, one entry per cycle, during which no input beat is taken.
module graph_embedding_scatter_accumulate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], node_a[11:2], node_b[21:12], label[25:22], value[57:26], zero pad
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], read_data[33:2], zero pad
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_data
);
    import gesa_pkg::*;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] num_nodes_reg;
    logic [4:0]         num_labels_reg;

    // Latched command beat
    logic [1:0]         cmd_reg;
    logic [NODE_W-1:0]  a_reg, b_reg;
    logic [LABEL_W-1:0] lab_reg;
    logic [DATA_W-1:0]  w_reg;

    logic [LABEL_W-1:0] la_reg, lb_reg;
    logic [COUNT_W-1:0] cnt_a_reg, cnt_b_reg;
    logic               second_reg;
    logic [1:0]         st_reg;
    logic [DATA_W-1:0]  rd_reg;
    logic [Z_AW-1:0]    tgt_reg;
    logic [Z_AW-1:0]    clr_reg;

    // Divider
    logic [COUNT_W-1:0] div_d_reg;
    logic [COUNT_W-1:0] div_rem_reg;
    logic [DATA_W-1:0]  div_q_reg;
    logic [STEP_W-1:0]  div_cnt_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [DATA_W-1:0]  out_data_reg;

    // Memories
    logic [LABEL_W-1:0] label_mem [MAX_NODES];
    logic [DATA_W-1:0]  z_mem [MAX_NODES*MAX_LABELS];
    logic [COUNT_W-1:0] count_reg [MAX_LABELS];
    logic [LABEL_W-1:0] lab_q;
    logic [DATA_W-1:0]  z_q;

    logic               accept;
    logic               a_ok, b_ok, lab_ok, la_ok, lb_ok;
    logic               lab_we, z_we;
    logic [NODE_W-1:0]  lab_raddr;
    logic [Z_AW-1:0]    z_addr;
    logic [DATA_W-1:0]  z_wdata;
    logic [DATA_W-1:0]  w_mag;
    logic [COUNT_W:0]   div_trial;
    logic               div_fit;
    logic [DATA_W:0]    quot;
    logic [DATA_W+1:0]  sum;
    logic [DATA_W-1:0]  sat;
    logic               out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign a_ok     = {1'b0, a_reg} < num_nodes_reg;
    assign b_ok     = {1'b0, b_reg} < num_nodes_reg;
    assign lab_ok   = {1'b0, lab_reg} < num_labels_reg;
    assign la_ok    = {1'b0, la_reg} < num_labels_reg;
    assign lb_ok    = {1'b0, lb_reg} < num_labels_reg;
    assign w_mag    = w_reg[DATA_W-1] ? (~w_reg + 1'b1) : w_reg;

    // One restoring step: shift in the next dividend bit, subtract when it fits
    assign div_trial = {div_rem_reg, div_q_reg[DATA_W-1]};
    assign div_fit   = div_trial >= {1'b0, div_d_reg};

    // Signed quotient and saturated sum with the stored entry
    assign quot = w_reg[DATA_W-1] ? (~{1'b0, div_q_reg} + 1'b1) : {1'b0, div_q_reg};
    assign sum  = {{2{z_q[DATA_W-1]}}, z_q} + {quot[DATA_W], quot};
    always_comb
    begin
        if (!sum[DATA_W+1] && (sum[DATA_W] || sum[DATA_W-1]))
            sat = {1'b0, {(DATA_W-1){1'b1}}};
        else if (sum[DATA_W+1] && !(sum[DATA_W] && sum[DATA_W-1]))
            sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat = sum[DATA_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == {Z_AW{1'b1}}) state_next = S_IDLE;
            S_IDLE:  if (accept) state_next = S_DISP;
            S_DISP:
            begin
                if (cmd_reg == CMD_EDGE)
                    state_next = (a_ok && b_ok) ? S_LA : S_RESP;
                else if (cmd_reg == CMD_READ && a_ok && lab_ok)
                    state_next = S_RDZ;
                else
                    state_next = S_RESP;
            end
            S_LA:    state_next = S_LB;
            S_LB:    state_next = S_CHK;
            S_CHK:
            begin
                if (!la_ok || !lb_ok || cnt_b_reg == '0 || (a_reg != b_reg && cnt_a_reg == '0))
                    state_next = S_RESP;
                else
                    state_next = S_DIV;
            end
            S_DIV:   if (div_cnt_reg == {STEP_W{1'b1}}) state_next = S_ZRD;
            S_ZRD:   state_next = S_ACC;
            S_ACC:   state_next = second_reg ? S_DIV : S_RESP;
            S_RDZ:   state_next = S_RESP;
            S_RESP:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Memory controls and the input handshake
    always_comb
    begin
        s_tready  = 1'b0;
        lab_we    = 1'b0;
        z_we      = 1'b0;
        lab_raddr = a_reg;
        z_addr    = tgt_reg;
        z_wdata   = sat;
        case (state_reg)
            S_CLEAR:
            begin
                z_we    = 1'b1;
                z_addr  = clr_reg;
                z_wdata = '0;
            end
            S_IDLE:  s_tready = 1'b1;
            S_DISP:
            begin
                z_addr  = {a_reg, lab_reg};
                z_wdata = w_reg;
                lab_we  = (cmd_reg == CMD_LOAD) && a_ok && lab_ok;
                z_we    = (cmd_reg == CMD_WRITE) && a_ok && lab_ok;
            end
            S_LA:    lab_raddr = b_reg;
            S_ACC:   z_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
            label_mem[a_reg] <= lab_reg;
        lab_q <= label_mem[lab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (z_we)
            z_mem[z_addr] <= z_wdata;
        z_q <= z_mem[z_addr];
    end

    // Label counts: saturating, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LABELS; i++)
                count_reg[i] <= '0;
        end
        else if (lab_we && count_reg[lab_reg] != {COUNT_W{1'b1}})
        begin
            count_reg[lab_reg] <= count_reg[lab_reg] + 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            num_nodes_reg  <= COUNT_W'(MAX_NODES);
            num_labels_reg <= 5'(MAX_LABELS);
            out_valid_reg  <= 1'b0;
            div_cnt_reg    <= '0;
            second_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_NUM_NODES:  num_nodes_reg  <= cfg_data;
                    REG_NUM_LABELS: num_labels_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_DIV)
                div_cnt_reg <= div_cnt_reg + 1'b1;
            if (state_reg == S_CHK)
                second_reg <= (a_reg != b_reg);
            else if (state_reg == S_ACC)
                second_reg <= 1'b0;
            if (state_reg == S_RESP && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tdata[1:0];
            a_reg   <= s_tdata[11:2];
            b_reg   <= s_tdata[21:12];
            lab_reg <= s_tdata[25:22];
            w_reg   <= s_tdata[57:26];
        end
        case (state_reg)
            S_DISP:
            begin
                rd_reg <= '0;
                if (!a_ok || (cmd_reg == CMD_EDGE && !b_ok))
                    st_reg <= ST_NODE;
                else if (cmd_reg != CMD_EDGE && !lab_ok)
                    st_reg <= ST_LABEL;
                else
                    st_reg <= ST_OK;
            end
            S_LA:
            begin
                la_reg    <= lab_q;
                cnt_a_reg <= count_reg[lab_q];
            end
            S_LB:
            begin
                lb_reg    <= lab_q;
                cnt_b_reg <= count_reg[lab_q];
            end
            S_CHK:
            begin
                if (!la_ok || !lb_ok)
                    st_reg <= ST_LABEL;
                else if (cnt_b_reg == '0 || (a_reg != b_reg && cnt_a_reg == '0))
                    st_reg <= ST_ZERO;
                div_d_reg   <= cnt_b_reg;
                div_rem_reg <= '0;
                div_q_reg   <= w_mag;
                tgt_reg     <= {a_reg, lb_reg};
            end
            S_DIV:
            begin
                div_rem_reg <= div_fit ? COUNT_W'(div_trial - {1'b0, div_d_reg})
                                       : div_trial[COUNT_W-1:0];
                div_q_reg   <= {div_q_reg[DATA_W-2:0], div_fit};
            end
            S_ACC:
            begin
                div_d_reg   <= cnt_a_reg;
                div_rem_reg <= '0;
                div_q_reg   <= w_mag;
                tgt_reg     <= {b_reg, la_reg};
            end
            S_RDZ:   rd_reg <= z_q;
            default: ;
        endcase
        if (state_reg == S_RESP && out_free)
        begin
            out_status_reg <= st_reg;
            out_data_reg   <= rd_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_data_reg, out_status_reg};

    a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DISP)
        else $error("accepted beat did not start dispatch");
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !s_tready)
        else $error("beat taken during clearing pass");
    a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result raised outside response state");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ZRD |-> $past(state_reg) == S_DIV && div_cnt_reg == '0)
        else $error("entry read before division finished");
endmodule

FILE: tb/graph_embedding_scatter_accumulate_tb.sv
// Self-checking testbench for graph_embedding_scatter_accumulate.
// Depends on gesa_pkg and the top level; holds a behavioral predictor and a scoreboard.
`timescale 1ns / 1ps
module graph_embedding_scatter_accumulate_tb;
    import gesa_pkg::*;

    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_data;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // cmd[1:0], node_a[11:2], node_b[21:12], label[25:22], value[57:26], zero pad
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // status[1:0], read_data[33:2], zero pad
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic        cfg_addr;
    logic [10:0] cfg_data;

    // Predictor state
    logic [10:0] pr_num_nodes;
    logic [4:0]  pr_num_labels;
    logic [3:0]  pr_label [MAX_NODES];
    bit          pr_labelled [MAX_NODES];
    logic [10:0] pr_count [MAX_LABELS];
    logic signed [31:0] pr_z [MAX_NODES*MAX_LABELS];

    result_t expected_results [$];
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_off;
    int      errors;
    int      quiet_cycles;

    graph_embedding_scatter_accumulate u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit node_valid(input logic [9:0] n);
        return {1'b0, n} < pr_num_nodes;
    endfunction

    function automatic bit label_valid(input logic [3:0] l);
        return {1'b0, l} < pr_num_labels;
    endfunction

    // Add w/cnt (truncated toward zero) into one entry, saturating to 32 bits.
    function automatic void scatter_add(input int idx, input logic signed [31:0] w,
                                        input logic [10:0] cnt);
        longint q;
        longint s;
        q = longint'(w) / longint'(cnt);
        s = longint'(pr_z[idx]) + q;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        pr_z[idx] = s[31:0];
    endfunction

    function automatic result_t predict_embedding(input logic [1:0] cmd, input logic [9:0] a,
                                                  input logic [9:0] b, input logic [3:0] lab,
                                                  input logic signed [31:0] w);
        result_t r;
        logic [3:0] la;
        logic [3:0] lb;
        r.status = ST_OK;
        r.read_data = '0;
        if (cmd == CMD_EDGE)
        begin
            if (!node_valid(a) || !node_valid(b))
                r.status = ST_NODE;
            else
            begin
                la = pr_label[a];
                lb = pr_label[b];
                if (!label_valid(la) || !label_valid(lb))
                    r.status = ST_LABEL;
                else if (pr_count[lb] == 0 || (a != b && pr_count[la] == 0))
                    r.status = ST_ZERO;
                else
                begin
                    scatter_add(a * MAX_LABELS + lb, w, pr_count[lb]);
                    if (a != b)
                        scatter_add(b * MAX_LABELS + la, w, pr_count[la]);
                end
            end
        end
        else if (!node_valid(a))
            r.status = ST_NODE;
        else if (!label_valid(lab))
            r.status = ST_LABEL;
        else if (cmd == CMD_LOAD)
        begin
            pr_label[a] = lab;
            pr_labelled[a] = 1'b1;
            if (pr_count[lab] < 11'd2047)
                pr_count[lab] = pr_count[lab] + 1'b1;
        end
        else if (cmd == CMD_WRITE)
            pr_z[a * MAX_LABELS + lab] = w;
        else
            r.read_data = pr_z[a * MAX_LABELS + lab];
        return r;
    endfunction

    // Idle for a random number of cycles, offer one beat, hold it until accepted,
    // then record the expectation. The caller drops tvalid when nothing follows.
    task automatic send_cmd(input logic [1:0] cmd, input logic [9:0] a, input logic [9:0] b,
                            input logic [3:0] lab, input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, w, lab, b, a, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_embedding(cmd, a, b, lab, w));
    endtask

    // Drain outstanding results, let the block settle, then write a register.
    task automatic write_reg(input logic addr, input logic [10:0] data);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_NUM_NODES) pr_num_nodes = data;
        else pr_num_labels = data[4:0];
    endtask

    // Pick a node that already carries a label, within the current range if possible.
    function automatic logic [9:0] pick_labelled();
        logic [9:0] n;
        for (int i = 0; i < 64; i++)
        begin
            n = 10'($urandom_range(pr_num_nodes > 0 ? pr_num_nodes - 1 : 0, 0));
            if (pr_labelled[n]) return n;
        end
        for (int i = 0; i < MAX_NODES; i++)
            if (pr_labelled[i]) return i[9:0];
        return 10'd0;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // One random item; edges only touch labelled nodes.
    task automatic send_random();
        logic [1:0] cmd;
        logic [9:0] a;
        logic [9:0] b;
        cmd = 2'($urandom_range(3));
        a = 10'($urandom_range(pr_num_nodes + 8 > 1023 ? 1023 : pr_num_nodes + 8, 0));
        if (cmd == CMD_EDGE)
        begin
            a = pick_labelled();
            b = ($urandom_range(9) == 0) ? a : pick_labelled();
            if (!pr_labelled[a] || !pr_labelled[b])
            begin
                cmd = CMD_LOAD;
            end
            else if ($urandom_range(15) == 0)
            begin
                // Out-of-range node b, rejected before any label lookup; b falls back to a if in range
                b = pr_num_nodes > 11'd1023 ? 10'd1023
                                            : 10'(pr_num_nodes + 11'($urandom_range(3)));
                if (node_valid(b)) b = a;
            end
        end
        else
            b = 10'($urandom);
        send_cmd(cmd, a, b, 4'($urandom_range(15)), rand_value());
    endtask

    task automatic test_directed();
        send_cmd(CMD_READ, 10'd0, 10'd0, 4'd0, 32'd0);
        send_cmd(CMD_WRITE, 10'd1023, 10'd0, 4'd15, 32'h7fffffff);
        send_cmd(CMD_READ, 10'd1023, 10'd0, 4'd15, 32'd0);
        send_cmd(CMD_LOAD, 10'd0, 10'd0, 4'd0, 32'd0);
        send_cmd(CMD_LOAD, 10'd1, 10'd0, 4'd15, 32'd0);
        send_cmd(CMD_EDGE, 10'd0, 10'd0, 4'd0, 32'h80000000);
        send_cmd(CMD_EDGE, 10'd0, 10'd1, 4'd0, 32'hfffe0001);
        send_cmd(CMD_LOAD, 10'd2, 10'd0, 4'd15, 32'd0);
        send_cmd(CMD_EDGE, 10'd1, 10'd2, 4'd3, 32'd3);
        send_cmd(CMD_EDGE, 10'd1, 10'd2, 4'd3, -32'sd3);
        send_cmd(CMD_READ, 10'd1, 10'd0, 4'd15, 32'd0);
        // Saturate both ways
        send_cmd(CMD_WRITE, 10'd0, 10'd0, 4'd15, 32'h7ffffff0);
        send_cmd(CMD_EDGE, 10'd0, 10'd1, 4'd0, 32'h7fffffff);
        send_cmd(CMD_READ, 10'd0, 10'd0, 4'd15, 32'd0);
        send_cmd(CMD_WRITE, 10'd1, 10'd0, 4'd0, 32'h80000010);
        send_cmd(CMD_EDGE, 10'd0, 10'd1, 4'd0, 32'h80000000);
        send_cmd(CMD_READ, 10'd1, 10'd0, 4'd0, 32'd0);
        // Relabel keeps old count; below, shrink/grow the ranges for rejections, then load fresh labels
        send_cmd(CMD_WRITE, 10'd3, 10'd1023, 4'd7, 32'h00010000);
        write_reg(REG_NUM_NODES, 11'd2);
        send_cmd(CMD_EDGE, 10'd0, 10'd2, 4'd0, 32'd5);
        send_cmd(CMD_READ, 10'd2, 10'd0, 4'd0, 32'd0);
        write_reg(REG_NUM_LABELS, 11'd1);
        send_cmd(CMD_EDGE, 10'd0, 10'd1, 4'd0, 32'd5);
        send_cmd(CMD_LOAD, 10'd1, 10'd0, 4'd1, 32'd0);
        write_reg(REG_NUM_NODES, 11'd1024);
        write_reg(REG_NUM_LABELS, 11'h7ff);
        send_cmd(CMD_LOAD, 10'd4, 10'd0, 4'd5, 32'd0);
        send_cmd(CMD_LOAD, 10'd5, 10'd0, 4'd6, 32'd0);
    endtask

    task automatic test_random(input int n_items, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n_items) send_random();
    endtask

    // Receiver holds off for a counted stretch while the sender keeps offering.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (20) send_random();
        join
    endtask

    // Repeated loads of one node and one load of another on a tiny graph, then an edge and a read.
    task automatic test_repeat_load();
        write_reg(REG_NUM_NODES, 11'd4);
        write_reg(REG_NUM_LABELS, 11'd16);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (100) send_cmd(CMD_LOAD, 10'd3, 10'd0, 4'd9, 32'd0);
        send_cmd(CMD_LOAD, 10'd2, 10'd0, 4'd9, 32'd0);
        send_cmd(CMD_EDGE, 10'd3, 10'd2, 4'd0, 32'h7fffffff);
        send_cmd(CMD_READ, 10'd3, 10'd0, 4'd9, 32'd0);
    endtask

    // Drive the receiver ready, holding it low during a hold-off stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = m_tdata[1:0];
            got.read_data = m_tdata[33:2];
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat status=%0d read_data=%h",
                       got.status, got.read_data);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.read_data !== exp_r.read_data)
                begin
                    $error("read_data expected %h actual %h", exp_r.read_data,
                           got.read_data);
                    errors++;
                end
            end
        end
    end

    // Watchdog: abort when nothing is accepted for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("FAIL graph_embedding_scatter_accumulate");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        errors = 0;
        quiet_cycles = 0;
        pr_num_nodes = 11'd1024;
        pr_num_labels = 5'd16;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            pr_label[i] = '0;
            pr_labelled[i] = 1'b0;
        end
        for (int i = 0; i < MAX_LABELS; i++) pr_count[i] = '0;
        for (int i = 0; i < MAX_NODES * MAX_LABELS; i++) pr_z[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(150, 0, 0);
        join
        write_reg(REG_NUM_NODES, 11'd16);
        write_reg(REG_NUM_LABELS, 11'd4);
        test_random(200, 54, 0);
        write_reg(REG_NUM_NODES, 11'd1);
        write_reg(REG_NUM_LABELS, 11'd16);
        test_random(100, 0, 54);
        write_reg(REG_NUM_NODES, 11'd1024);
        write_reg(REG_NUM_LABELS, 11'd3);
        test_random(200, 32, 32);
        write_reg(REG_NUM_NODES, 11'd0);
        write_reg(REG_NUM_LABELS, 11'd0);
        test_random(30, 0, 0);
        write_reg(REG_NUM_NODES, 11'd64);
        write_reg(REG_NUM_LABELS, 11'd16);
        test_random(150, 32, 32);
        test_repeat_load();
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS graph_embedding_scatter_accumulate");
        else
            $display("FAIL graph_embedding_scatter_accumulate");
        $finish;
    end
endmodule
